// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: always");

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/pdsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdsc_pkg
// Types and codes of the packet deframer with negated-sum checksum.
// ----------------------------------------------------------------------------
package pdsc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CfgIdxW = 8;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [SumW-1:0]  sum_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_HEADER = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_TAIL   = 8'd1;

  // deframer phase
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_DATA = 3'd2,
    PH_CK1  = 3'd3,
    PH_CK2  = 3'd4,
    PH_TAIL = 3'd5
  } phase_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DATA      = 3'd1,
    EV_GOOD      = 3'd2,
    EV_CKSUM_BAD = 3'd3,
    EV_TAIL_BAD  = 3'd4
  } event_t;

  // one result word
  typedef struct packed {
    event_t event_res;
    byte_t  data_byte;
    byte_t  byte_index;
    byte_t  frame_length;
  } result_t;

endpackage

// ----- rtl/pdsc_if.sv -----
// ----------------------------------------------------------------------------
// pdsc_in_if / pdsc_out_if
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface pdsc_in_if;
  logic            valid;
  logic            ready;
  pdsc_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdsc_out_if;
  logic             valid;
  logic             ready;
  pdsc_pkg::event_t event_res;
  pdsc_pkg::byte_t  data_byte;
  pdsc_pkg::byte_t  byte_index;
  pdsc_pkg::byte_t  frame_length;

  modport source (output valid, output event_res, output data_byte,
                  output byte_index, output frame_length, input ready);
  modport sink   (input valid, input event_res, input data_byte,
                  input byte_index, input frame_length, output ready);
endinterface

// ----- rtl/pdsc_skid.sv -----
// ----------------------------------------------------------------------------
// pdsc_skid
// Output register with one skid entry: upstream keeps moving for one word
// after the downstream side stalls.
// ----------------------------------------------------------------------------
module pdsc_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pdsc_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pdsc_pkg::result_t out_data
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  pdsc_pkg::result_t out_data_r, out_data_nxt;
  pdsc_pkg::result_t skid_data_r, skid_data_nxt;
  logic              push, pop;

  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // refill the output register from skid first, then from the input
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      out_data_nxt   = skid_valid_r ? skid_data_r : in_data;
      out_valid_nxt  = skid_valid_r || push;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_data_nxt  = in_data;
      skid_valid_nxt = 1'b1;
    end
  end

  // control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload flops
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// ----- rtl/packet_deframer_sum_checksum_core.sv -----
// ----------------------------------------------------------------------------
// packet_deframer_sum_checksum_core
// Byte-stream deframer: header, length, payload, 16-bit negated-sum checksum
// (low byte first) and tail. One result word per received byte.
// ----------------------------------------------------------------------------
// Output: each accepted byte's result is registered in the skid buffer.
// Throughput: 1 byte per cycle; the state update and running sum complete in
//   the accept cycle, and a skid entry keeps input flowing for one word
//   while the output is stalled.
// Reset: synchronous active-low rst_n; phase returns to header hunting,
//   counters, sum and both config registers clear to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packet_deframer_sum_checksum_core (
  input  logic                                clk,
  input  logic                                rst_n,
  pdsc_in_if.sink                             in_ch,
  pdsc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [pdsc_pkg::CfgIdxW-1:0]        cfg_index,
  input  pdsc_pkg::byte_t                     cfg_data
);

  // config registers
  pdsc_pkg::byte_t header_r, tail_r;

  // deframer state
  pdsc_pkg::phase_t phase_r, phase_nxt;
  pdsc_pkg::byte_t  exp_len_r, exp_len_nxt;
  pdsc_pkg::byte_t  taken_r, taken_nxt;
  pdsc_pkg::sum_t   sum_r, sum_nxt;
  pdsc_pkg::byte_t  ck_low_r, ck_low_nxt;

  pdsc_pkg::result_t res;
  pdsc_pkg::result_t out_word;
  pdsc_pkg::byte_t   b;
  pdsc_pkg::sum_t    ck_sum;
  logic              in_ready;
  logic              accept;

  assign b            = in_ch.rx_byte;
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;
  // received checksum plus payload sum must wrap to zero
  assign ck_sum       = {b, ck_low_r} + sum_r;

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      tail_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pdsc_pkg::REG_HEADER) header_r <= cfg_data;
      else if (cfg_index == pdsc_pkg::REG_TAIL) tail_r <= cfg_data;
    end
  end

  // next state and result for the byte at the input
  always_comb begin
    phase_nxt        = phase_r;
    exp_len_nxt      = exp_len_r;
    taken_nxt        = taken_r;
    sum_nxt          = sum_r;
    ck_low_nxt       = ck_low_r;
    res.event_res    = pdsc_pkg::EV_NONE;
    res.data_byte    = '0;
    res.byte_index   = '0;
    res.frame_length = '0;
    unique case (phase_r)
      pdsc_pkg::PH_LEN: begin
        if (b != '0) begin
          exp_len_nxt = b;
          taken_nxt   = '0;
          sum_nxt     = '0;
          phase_nxt   = pdsc_pkg::PH_DATA;
        end else begin
          phase_nxt   = pdsc_pkg::PH_HUNT;
        end
      end
      pdsc_pkg::PH_DATA: begin
        res.event_res    = pdsc_pkg::EV_DATA;
        res.data_byte    = b;
        res.byte_index   = taken_r;
        res.frame_length = exp_len_r;
        sum_nxt          = sum_r + {8'd0, b};
        taken_nxt        = taken_r + 8'd1;
        if (taken_nxt == exp_len_r) phase_nxt = pdsc_pkg::PH_CK1;
      end
      pdsc_pkg::PH_CK1: begin
        ck_low_nxt = b;
        phase_nxt  = pdsc_pkg::PH_CK2;
      end
      pdsc_pkg::PH_CK2: begin
        if (ck_sum == '0) begin
          phase_nxt = pdsc_pkg::PH_TAIL;
        end else begin
          res.event_res    = pdsc_pkg::EV_CKSUM_BAD;
          res.frame_length = exp_len_r;
          phase_nxt        = pdsc_pkg::PH_HUNT;
        end
      end
      pdsc_pkg::PH_TAIL: begin
        res.event_res    = (b == tail_r) ? pdsc_pkg::EV_GOOD : pdsc_pkg::EV_TAIL_BAD;
        res.frame_length = exp_len_r;
        phase_nxt        = pdsc_pkg::PH_HUNT;
      end
      default: begin
        // header hunting; unused codes land here too
        phase_nxt = (b == header_r) ? pdsc_pkg::PH_LEN : pdsc_pkg::PH_HUNT;
      end
    endcase
  end

  // state registers advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= pdsc_pkg::PH_HUNT;
      exp_len_r <= '0;
      taken_r   <= '0;
      sum_r     <= '0;
      ck_low_r  <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      exp_len_r <= exp_len_nxt;
      taken_r   <= taken_nxt;
      sum_r     <= sum_nxt;
      ck_low_r  <= ck_low_nxt;
    end
  end

  // result register with skid entry
  pdsc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_data   (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_word)
  );

  assign out_ch.event_res    = out_word.event_res;
  assign out_ch.data_byte    = out_word.data_byte;
  assign out_ch.byte_index   = out_word.byte_index;
  assign out_ch.frame_length = out_word.frame_length;

  // checks
  `ASSERT_IMPL(a_taken_below_len, phase_r == pdsc_pkg::PH_DATA, taken_r < exp_len_r)
  `ASSERT_IMPL(a_data_has_len, out_ch.valid && out_ch.event_res == pdsc_pkg::EV_DATA, out_ch.frame_length != '0)
  `ASSERT_NEXT(a_taken_step, accept && phase_r == pdsc_pkg::PH_DATA, taken_r == pdsc_pkg::byte_t'($past(taken_r) + 8'd1))
  `ASSERT_NEXT(a_len_clears_sum, accept && phase_r == pdsc_pkg::PH_LEN && b != '0, sum_r == '0 && phase_r == pdsc_pkg::PH_DATA)

endmodule
